// ===== design/heightmap_bilinear_sampler_assert.svh =====
// Assertion macros for the heightmap sampler. They expand to nothing in synthesis.
`ifndef HEIGHTMAP_BILINEAR_SAMPLER_ASSERT_SVH
`define HEIGHTMAP_BILINEAR_SAMPLER_ASSERT_SVH
`ifndef SYNTHESIS
`define HBS_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("heightmap sampler check failed");
`define HBS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("heightmap sampler check failed");
`else
`define HBS_ASSERT_SAME(label, ante, cons)
`define HBS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== design/hbs_pkg.sv =====
package hbs_pkg;

	localparam int GRID_WIDTH = 256;
	localparam int GRID_DEPTH = 256;
	localparam int FRAC_BITS  = 8;

	localparam int X_BITS    = $clog2(GRID_WIDTH);
	localparam int Z_BITS    = $clog2(GRID_DEPTH);
	localparam int BANK_AW   = X_BITS - 1 + Z_BITS;

	localparam int CELL_W    = 8;
	localparam int SAMPLE_W  = 8;
	localparam int POS_W     = 17;
	localparam int IPART_W   = POS_W - 1 - FRAC_BITS;
	localparam int ONE_W     = FRAC_BITS + 1;
	localparam int SCALE_W   = 16;
	localparam int OFFSET_W  = 16;
	localparam int HEIGHT_W  = 16;

	localparam int LERP_W    = SAMPLE_W + FRAC_BITS;
	localparam int BLEND_W   = SAMPLE_W + 2 * FRAC_BITS;
	localparam int PROD_W    = BLEND_W + SCALE_W;
	localparam int RND_SHIFT = 2 * FRAC_BITS + 8;
	localparam int HSUM_W    = PROD_W + 1 - RND_SHIFT;

	localparam int IN_BITS    = 3 * CELL_W + 2 * POS_W;
	localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
	localparam int CFG_IDX_W  = 1;

	localparam logic [SCALE_W-1:0]  SCALE_RESET  = 16'd6554;
	localparam logic [OFFSET_W-1:0] OFFSET_RESET = 16'hE000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HEIGHT_SCALE  = 1'b0,
		REG_HEIGHT_OFFSET = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		REQ_LOAD  = 1'b0,
		REQ_QUERY = 1'b1
	} req_t;

	// The four grid samples around a query point and its fractional position.
	typedef struct packed {
		logic [SAMPLE_W-1:0]  s00;
		logic [SAMPLE_W-1:0]  s01;
		logic [SAMPLE_W-1:0]  s10;
		logic [SAMPLE_W-1:0]  s11;
		logic [FRAC_BITS-1:0] fx;
		logic [FRAC_BITS-1:0] fz;
	} corners_t;

endpackage

// ===== design/heightmap_bilinear_sampler.sv =====
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tdata: cell_x, cell_z, sample_value, pos_x, pos_z
//                                               tuser: req_type
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata: height; tuser: in_grid
// cfg       in   cfg_valid/cfg_ready            cfg_index, cfg_data
//
// A load is taken in the idle state and does not leave it. A query in the grid passes through the
// bank reads (rows z and z+1), the state that presents the corners, three multiply stages ending
// in the offset add, the load of the output register and the idle state that takes the next item.
// A query outside the grid goes from the idle state straight to the output state.
// The output register lets the next item enter while a result waits; a further query then
// holds in the last state until the output is free. Reset leaves the grid memory uncleared.
`include "heightmap_bilinear_sampler_assert.svh"

module heightmap_bilinear_sampler import hbs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// cell_x[7:0], cell_z[15:8], sample_value[23:16], pos_x[40:24], pos_z[57:41], zeros above
	input  logic [IN_TDATA_W-1:0] s_axis_tdata,
	// req_type[0]
	input  logic [0:0]            s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// height[15:0]
	output logic [HEIGHT_W-1:0]   m_axis_tdata,
	// in_grid[0]
	output logic [0:0]            m_axis_tuser,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [15:0]           cfg_data
);

	// The FSM walks one query at a time through the bank reads and the blend pipeline.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD0,
		ST_RD1,
		ST_RD2,
		ST_WAIT,
		ST_OUT
	} state_t;

	state_t state_q;

	logic [CELL_W-1:0]   cell_x;
	logic [CELL_W-1:0]   cell_z;
	logic [SAMPLE_W-1:0] sample_value;
	logic [POS_W-1:0]    pos_x;
	logic [POS_W-1:0]    pos_z;
	logic                req_type;

	assign cell_x       = s_axis_tdata[CELL_W-1:0];
	assign cell_z       = s_axis_tdata[2*CELL_W-1:CELL_W];
	assign sample_value = s_axis_tdata[3*CELL_W-1:2*CELL_W];
	assign pos_x        = s_axis_tdata[3*CELL_W+POS_W-1:3*CELL_W];
	assign pos_z        = s_axis_tdata[3*CELL_W+2*POS_W-1:3*CELL_W+POS_W];
	assign req_type     = s_axis_tuser[0];

	logic in_acc;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	// Configuration registers are always writable; the user writes them only while idle.
	logic [SCALE_W-1:0]  scale_q;
	logic [OFFSET_W-1:0] offset_q;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q  <= SCALE_RESET;
			offset_q <= OFFSET_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_HEIGHT_SCALE:  scale_q  <= cfg_data[SCALE_W-1:0];
				REG_HEIGHT_OFFSET: offset_q <= cfg_data[OFFSET_W-1:0];
				default: ;
			endcase
		end
	end

	// Query decode. The integer part is checked in full, so negative positions and
	// positions on or past the last row or column fall outside the grid.
	logic [IPART_W-1:0] ix_full;
	logic [IPART_W-1:0] iz_full;
	logic               q_outside;
	logic [X_BITS-1:0]  ix;
	logic [X_BITS:0]    ix_plus1;

	assign ix_full   = pos_x[POS_W-2:FRAC_BITS];
	assign iz_full   = pos_z[POS_W-2:FRAC_BITS];
	assign q_outside = pos_x[POS_W-1] || pos_z[POS_W-1]
		|| (32'(ix_full) >= GRID_WIDTH - 1) || (32'(iz_full) >= GRID_DEPTH - 1);
	assign ix        = ix_full[X_BITS-1:0];
	assign ix_plus1  = {1'b0, ix} + (X_BITS + 1)'(1);

	// The grid is split by the parity of X, so columns ix and ix+1 always sit in
	// different banks and both are read in the same cycle.
	logic [X_BITS-2:0]    row0_q;
	logic [X_BITS-2:0]    row1_q;
	logic                 xodd_q;
	logic [Z_BITS-1:0]    iz_q;
	logic [FRAC_BITS-1:0] fx_q;
	logic [FRAC_BITS-1:0] fz_q;

	logic                load_ok;
	logic [1:0]          bank_we;
	logic [BANK_AW-1:0]  wr_addr;
	logic                rd_en;
	logic [Z_BITS-1:0]   rd_z;
	logic [SAMPLE_W-1:0] bank0_rd;
	logic [SAMPLE_W-1:0] bank1_rd;

	assign load_ok = in_acc && (req_type == REQ_LOAD)
		&& (32'(cell_x) < GRID_WIDTH) && (32'(cell_z) < GRID_DEPTH);
	assign bank_we = {load_ok && cell_x[0], load_ok && !cell_x[0]};
	assign wr_addr = {cell_x[X_BITS-1:1], cell_z[Z_BITS-1:0]};
	assign rd_en   = (state_q == ST_RD0) || (state_q == ST_RD1);
	assign rd_z    = (state_q == ST_RD0) ? iz_q : Z_BITS'(iz_q + 1'b1);

	hbs_bank_ram #(
		.ADDR_W (BANK_AW),
		.DATA_W (SAMPLE_W)
	) u_bank_even (
		.clk     (clk),
		.we      (bank_we[0]),
		.wr_addr (wr_addr),
		.wr_data (sample_value),
		.re      (rd_en),
		.rd_addr ({row0_q, rd_z}),
		.rd_data (bank0_rd)
	);

	hbs_bank_ram #(
		.ADDR_W (BANK_AW),
		.DATA_W (SAMPLE_W)
	) u_bank_odd (
		.clk     (clk),
		.we      (bank_we[1]),
		.wr_addr (wr_addr),
		.wr_data (sample_value),
		.re      (rd_en),
		.rd_addr ({row1_q, rd_z}),
		.rd_data (bank1_rd)
	);

	// Samples of row z are held while row z+1 is read; the four corners then go to the blend.
	logic [SAMPLE_W-1:0] lo_z0_q;
	logic [SAMPLE_W-1:0] hi_z0_q;
	corners_t            corners;
	logic                blend_valid;
	logic [HSUM_W-1:0]   blend_sum;

	always_comb begin
		corners.s00 = lo_z0_q;
		corners.s10 = hi_z0_q;
		corners.s01 = xodd_q ? bank1_rd : bank0_rd;
		corners.s11 = xodd_q ? bank0_rd : bank1_rd;
		corners.fx  = fx_q;
		corners.fz  = fz_q;
	end

	hbs_blend u_blend (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (state_q == ST_RD2),
		.corners   (corners),
		.scale     (scale_q),
		.out_valid (blend_valid),
		.out_sum   (blend_sum)
	);

	// Offset add with saturation to the signed 16-bit range.
	localparam int SUM_W = HSUM_W + 2;
	logic signed [SUM_W-1:0] h_sum;
	logic [HEIGHT_W-1:0]     h_sat;

	always_comb begin
		h_sum = $signed({2'b00, blend_sum}) + $signed(SUM_W'($signed(offset_q)));
		if (h_sum > $signed(SUM_W'(32767))) begin
			h_sat = {1'b0, {(HEIGHT_W-1){1'b1}}};
		end else if (h_sum < -$signed(SUM_W'(32768))) begin
			h_sat = {1'b1, {(HEIGHT_W-1){1'b0}}};
		end else begin
			h_sat = h_sum[HEIGHT_W-1:0];
		end
	end

	logic [HEIGHT_W-1:0] h_q;
	logic                grid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			m_axis_tvalid <= 1'b0;
		end else begin
			// In the output state the valid flag is either reloaded or held below.
			if (m_axis_tvalid && m_axis_tready && (state_q != ST_OUT)) begin
				m_axis_tvalid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && (req_type == REQ_QUERY)) begin
						if (q_outside) begin
							h_q     <= '0;
							grid_q  <= 1'b0;
							state_q <= ST_OUT;
						end else begin
							row0_q  <= ix_plus1[X_BITS-1:1];
							row1_q  <= ix[X_BITS-1:1];
							xodd_q  <= ix[0];
							iz_q    <= iz_full[Z_BITS-1:0];
							fx_q    <= pos_x[FRAC_BITS-1:0];
							fz_q    <= pos_z[FRAC_BITS-1:0];
							state_q <= ST_RD0;
						end
					end
				end
				ST_RD0: begin
					state_q <= ST_RD1;
				end
				ST_RD1: begin
					lo_z0_q <= xodd_q ? bank1_rd : bank0_rd;
					hi_z0_q <= xodd_q ? bank0_rd : bank1_rd;
					state_q <= ST_RD2;
				end
				ST_RD2: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (blend_valid) begin
						h_q     <= h_sat;
						grid_q  <= 1'b1;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!m_axis_tvalid || m_axis_tready) begin
						m_axis_tvalid   <= 1'b1;
						m_axis_tdata    <= h_q;
						m_axis_tuser[0] <= grid_q;
						state_q         <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// A result outside the grid always carries a zero height.
	`HBS_ASSERT_SAME(a_outside_zero, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == '0)
	// The blend pipeline only finishes while the FSM is waiting for it.
	`HBS_ASSERT_SAME(a_blend_in_wait, blend_valid, state_q == ST_WAIT)
	// An accepted query always leaves the idle state.
	`HBS_ASSERT_NEXT(a_query_busy, in_acc && (req_type == REQ_QUERY), state_q != ST_IDLE)

endmodule

// ===== design/hbs_bank_ram.sv =====
module hbs_bank_ram #(
	parameter int ADDR_W = 15,
	parameter int DATA_W = 8
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              re,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== design/hbs_blend.sv =====
module hbs_blend import hbs_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  corners_t            corners,
	input  logic [SCALE_W-1:0]  scale,
	output logic                out_valid,
	output logic [HSUM_W-1:0]   out_sum
);

	localparam logic [ONE_W-1:0]  ONE     = ONE_W'(1) << FRAC_BITS;
	localparam logic [PROD_W:0]   RND_ADD = (PROD_W + 1)'(1) << (RND_SHIFT - 1);

	logic [ONE_W-1:0]     gx;
	logic [ONE_W-1:0]     gz_s1;
	logic [FRAC_BITS-1:0] fz_s1;
	logic [LERP_W-1:0]    a0_s1;
	logic [LERP_W-1:0]    a1_s1;
	logic [BLEND_W-1:0]   b_s2;
	logic [PROD_W-1:0]    prod_s3;
	logic                 v_s1;
	logic                 v_s2;
	logic                 v_s3;
	logic [PROD_W:0]      rounded;

	assign gx = ONE - ONE_W'(corners.fx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// First lerp along X, then along Z, then apply the gain.
	always_ff @(posedge clk) begin
		a0_s1   <= LERP_W'(corners.s00) * LERP_W'(gx) + LERP_W'(corners.s10) * LERP_W'(corners.fx);
		a1_s1   <= LERP_W'(corners.s01) * LERP_W'(gx) + LERP_W'(corners.s11) * LERP_W'(corners.fx);
		gz_s1   <= ONE - ONE_W'(corners.fz);
		fz_s1   <= corners.fz;
		b_s2    <= BLEND_W'(a0_s1) * BLEND_W'(gz_s1) + BLEND_W'(a1_s1) * BLEND_W'(fz_s1);
		prod_s3 <= PROD_W'(b_s2) * PROD_W'(scale);
	end

	assign rounded   = {1'b0, prod_s3} + RND_ADD;
	assign out_sum   = rounded[PROD_W:RND_SHIFT];
	assign out_valid = v_s3;

endmodule

// ===== tb/sv/heightmap_bilinear_sampler_tb.sv =====
// Self-checking bench for the heightmap sampler.
// A scripted opening walks a short table of loads, queries and register writes.
// The table covers the out-of-grid cases, the corners of the grid and saturation.
// Randomized phases follow. Each phase runs under its own scale and offset.
// Most of each phase loads a fresh 2x2 patch of samples and then queries inside it.
// The rest queries older patches, goes out of the grid on purpose, or loads lone cells.
// A query only ever touches cells that were loaded before it.
// Every result is compared against a local model of the bilinear blend.
module heightmap_bilinear_sampler_tb import hbs_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SETTLE_CYCLES = 20;      // covers a load still in flight when the queue drains
	localparam int PHASE_ITEMS   = 220;
	localparam int NUM_PHASES    = 7;
	localparam int NUM_DIRECTED  = 23;
	localparam int HOLD_CYCLES   = 400;
	localparam int IDLE_PERCENT  = 22;
	localparam int CYCLE_LIMIT   = 500000;
	localparam int MAX_PATCHES   = 64;

	typedef longint unsigned u64_t;

	typedef struct packed {
		logic [HEIGHT_W-1:0] height;
		logic                in_grid;
	} height_result_t;

	typedef struct packed {
		req_t                kind;
		logic [CELL_W-1:0]   cell_x;
		logic [CELL_W-1:0]   cell_z;
		logic [SAMPLE_W-1:0] sample;
		logic [POS_W-1:0]    pos_x;
		logic [POS_W-1:0]    pos_z;
	} grid_item_t;

	// One line of the opening script: either a register write or an item.
	// The expected result is written out only where it is obvious by inspection.
	typedef struct {
		bit             is_cfg;
		cfg_reg_t       cfg_sel;
		logic [15:0]    cfg_val;
		grid_item_t     item;
		bit             typed;
		height_result_t want;
	} script_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_TDATA_W-1:0] s_axis_tdata;
	logic [0:0]            s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [HEIGHT_W-1:0]   m_axis_tdata;
	logic [0:0]            m_axis_tuser;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [15:0]           cfg_data;

	// Local copy of the block's state. The grid copy is only read where it was written.
	logic [SAMPLE_W-1:0] grid_copy [0:GRID_WIDTH-1][0:GRID_DEPTH-1];
	logic [SCALE_W-1:0]  scale_now;
	shortint             offset_now;

	height_result_t pending_heights [$];
	logic [15:0]    loaded_patches [$];   // {x, z} origins whose four cells are loaded
	script_row_t    directed_rows [NUM_DIRECTED];

	int items_sent;
	int mismatches;
	int cycle_count;
	bit no_gaps;
	bit hold_request;

	heightmap_bilinear_sampler u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Bilinear blend of the four cells around the position, then scale, round half up,
	// add the offset and clamp. Negative positions and the last row or column are outside.
	function automatic height_result_t predict_height(logic [POS_W-1:0] px, logic [POS_W-1:0] pz);
		height_result_t r;
		int             ix;
		int             iz;
		u64_t           fx;
		u64_t           fz;
		u64_t           gx;
		u64_t           gz;
		u64_t           blend;
		u64_t           scaled;
		longint         level;
		r = '0;
		if (px[POS_W-1] || pz[POS_W-1]) begin
			return r;
		end
		ix = int'(px[POS_W-2:FRAC_BITS]);
		iz = int'(pz[POS_W-2:FRAC_BITS]);
		if (ix >= GRID_WIDTH - 1 || iz >= GRID_DEPTH - 1) begin
			return r;
		end
		fx = u64_t'(px[FRAC_BITS-1:0]);
		fz = u64_t'(pz[FRAC_BITS-1:0]);
		gx = (u64_t'(1) << FRAC_BITS) - fx;
		gz = (u64_t'(1) << FRAC_BITS) - fz;
		blend = u64_t'(grid_copy[ix][iz]) * gx * gz
		      + u64_t'(grid_copy[ix][iz+1]) * gx * fz
		      + u64_t'(grid_copy[ix+1][iz]) * fx * gz
		      + u64_t'(grid_copy[ix+1][iz+1]) * fx * fz;
		scaled = (blend * u64_t'(scale_now) + (u64_t'(1) << (RND_SHIFT - 1))) >> RND_SHIFT;
		level = longint'(scaled) + longint'(offset_now);
		if (level > 32767) begin
			level = 32767;
		end
		if (level < -32768) begin
			level = -32768;
		end
		r.height = level[HEIGHT_W-1:0];
		r.in_grid = 1'b1;
		return r;
	endfunction

	task automatic report_mismatch(string what, int want, int got);
		$display("[%0t] mismatch in %s: expected %0h, got %0h", $realtime, what, want, got);
		mismatches++;
	endtask

	function automatic logic [7:0] pick_sample();
		case ($urandom_range(0, 9))
			0: begin
				return 8'd0;
			end
			1: begin
				return 8'd255;
			end
			default: begin
				return 8'($urandom);
			end
		endcase
	endfunction

	function automatic logic [7:0] pick_origin();
		case ($urandom_range(0, 9))
			0: begin
				return 8'd0;
			end
			1: begin
				return 8'(GRID_WIDTH - 2);
			end
			default: begin
				return 8'($urandom_range(0, GRID_WIDTH - 2));
			end
		endcase
	endfunction

	function automatic logic [FRAC_BITS-1:0] pick_frac();
		case ($urandom_range(0, 7))
			0: begin
				return '0;
			end
			1: begin
				return '1;
			end
			default: begin
				return FRAC_BITS'($urandom);
			end
		endcase
	endfunction

	// Unused fields of either kind of item carry random bits.
	function automatic grid_item_t make_load(logic [7:0] x, logic [7:0] z, logic [7:0] v);
		grid_item_t it;
		it.kind = REQ_LOAD;
		it.cell_x = x;
		it.cell_z = z;
		it.sample = v;
		it.pos_x = POS_W'($urandom);
		it.pos_z = POS_W'($urandom);
		return it;
	endfunction

	function automatic grid_item_t make_query(logic [POS_W-1:0] px, logic [POS_W-1:0] pz);
		grid_item_t it;
		it.kind = REQ_QUERY;
		it.cell_x = 8'($urandom);
		it.cell_z = 8'($urandom);
		it.sample = 8'($urandom);
		it.pos_x = px;
		it.pos_z = pz;
		return it;
	endfunction

	// A query that misses the grid: negative on one axis, or on the last row or column.
	function automatic grid_item_t make_outside_query();
		logic [POS_W-1:0] neg;
		logic [POS_W-1:0] rim;
		logic [POS_W-1:0] any;
		neg = {1'b1, 16'($urandom)};
		rim = {1'b0, 8'(GRID_WIDTH - 1), 8'($urandom)};
		any = POS_W'($urandom);
		case ($urandom_range(0, 3))
			0: begin
				return make_query(neg, any);
			end
			1: begin
				return make_query(any, neg);
			end
			2: begin
				return make_query(rim, any);
			end
			default: begin
				return make_query(any, rim);
			end
		endcase
	endfunction

	function automatic script_row_t item_row(grid_item_t it);
		script_row_t r;
		r.is_cfg = 1'b0;
		r.cfg_sel = REG_HEIGHT_SCALE;
		r.cfg_val = '0;
		r.item = it;
		r.typed = 1'b0;
		r.want = '0;
		return r;
	endfunction

	function automatic script_row_t load_row(logic [7:0] x, logic [7:0] z, logic [7:0] v);
		return item_row(make_load(x, z, v));
	endfunction

	function automatic script_row_t query_row(logic [POS_W-1:0] px, logic [POS_W-1:0] pz);
		return item_row(make_query(px, pz));
	endfunction

	function automatic script_row_t checked_row(logic [POS_W-1:0] px, logic [POS_W-1:0] pz,
			logic [HEIGHT_W-1:0] h, logic g);
		script_row_t r;
		r = item_row(make_query(px, pz));
		r.typed = 1'b1;
		r.want.height = h;
		r.want.in_grid = g;
		return r;
	endfunction

	function automatic script_row_t cfg_row(cfg_reg_t sel, logic [15:0] v);
		script_row_t r;
		r = item_row('0);
		r.is_cfg = 1'b1;
		r.cfg_sel = sel;
		r.cfg_val = v;
		return r;
	endfunction

	// Offers one item, with random idle cycles in front of it, and books its result
	// at the edge where it is taken. Valid stays up afterwards for the next caller.
	task automatic send_item(grid_item_t it, bit typed, height_result_t want);
		while (!no_gaps && $urandom_range(0, 99) < IDLE_PERCENT) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= it.kind;
		s_axis_tdata <= IN_TDATA_W'({it.pos_z, it.pos_x, it.sample, it.cell_z, it.cell_x});
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
		if (it.kind == REQ_LOAD) begin
			grid_copy[it.cell_x][it.cell_z] = it.sample;
		end else begin
			pending_heights.push_back(typed ? want : predict_height(it.pos_x, it.pos_z));
		end
	endtask

	task automatic write_reg(cfg_reg_t sel, logic [15:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= sel;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		if (sel == REG_HEIGHT_SCALE) begin
			scale_now = v;
		end else begin
			offset_now = shortint'(v);
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Drains every booked result, then lets a trailing load finish.
	task automatic wait_idle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_heights.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// The main random sequence: a fresh 2x2 patch, then a few queries inside it.
	task automatic load_patch_and_query();
		logic [7:0] ox;
		logic [7:0] oz;
		int         n;
		ox = pick_origin();
		oz = pick_origin();
		for (int dx = 0; dx < 2; dx++) begin
			for (int dz = 0; dz < 2; dz++) begin
				send_item(make_load(8'(ox + dx), 8'(oz + dz), pick_sample()), 1'b0, '0);
			end
		end
		loaded_patches.push_back({ox, oz});
		if (loaded_patches.size() > MAX_PATCHES) begin
			void'(loaded_patches.pop_front());
		end
		n = $urandom_range(1, 3);
		repeat (n) begin
			send_item(make_query({1'b0, ox, pick_frac()}, {1'b0, oz, pick_frac()}), 1'b0, '0);
		end
	endtask

	task automatic query_old_patch();
		logic [15:0] p;
		p = loaded_patches[$urandom_range(0, loaded_patches.size() - 1)];
		send_item(make_query({1'b0, p[15:8], pick_frac()}, {1'b0, p[7:0], pick_frac()}),
			1'b0, '0);
	endtask

	// Result side: random back-pressure, a gap-free stretch, and one long hold-off
	// during which the sender keeps offering items until the block stops taking them.
	initial begin : result_sink
		int hold_left;
		hold_left = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (no_gaps) begin
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
			end
		end
	end

	// Each result taken is matched against the oldest booked query.
	always @(posedge clk) begin : result_check
		height_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_heights.size() == 0) begin
				report_mismatch("result with no query waiting", 0, m_axis_tdata);
			end else begin
				want = pending_heights.pop_front();
				if (m_axis_tdata !== want.height) begin
					report_mismatch("height", want.height, m_axis_tdata);
				end
				if (m_axis_tuser[0] !== want.in_grid) begin
					report_mismatch("in_grid", want.in_grid, m_axis_tuser[0]);
				end
			end
		end
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	initial begin : stimulus
		logic [15:0] next_scale;
		logic [15:0] next_offset;
		int          phase_end;
		int          pick;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_HEIGHT_SCALE;
		cfg_data = '0;
		scale_now = SCALE_RESET;
		offset_now = shortint'(OFFSET_RESET);
		items_sent = 0;
		mismatches = 0;
		no_gaps = 1'b0;
		hold_request = 1'b0;

		// Opening script. Under the reset registers an all-zero patch reads back as the
		// bare offset. Later rows pin full scale with top offset to positive saturation,
		// and zero scale with the lowest offset to the bottom of the range.
		directed_rows = '{
			checked_row(17'h10000, 17'h00000, 16'h0000, 1'b0),   // most negative X
			checked_row(17'h00000, 17'h1FFFF, 16'h0000, 1'b0),   // Z just below zero
			checked_row(17'h0FF00, 17'h00080, 16'h0000, 1'b0),   // X on the last column
			checked_row(17'h00000, 17'h0FF00, 16'h0000, 1'b0),   // Z on the last row
			checked_row(17'h0FFFF, 17'h0FFFF, 16'h0000, 1'b0),   // largest positions
			load_row(8'd0, 8'd0, 8'd0),
			load_row(8'd0, 8'd1, 8'd0),
			load_row(8'd1, 8'd0, 8'd0),
			load_row(8'd1, 8'd1, 8'd0),
			checked_row(17'h00000, 17'h00000, 16'hE000, 1'b1),
			load_row(8'd254, 8'd254, 8'd255),
			load_row(8'd254, 8'd255, 8'd255),
			load_row(8'd255, 8'd254, 8'd255),
			load_row(8'd255, 8'd255, 8'd255),
			query_row(17'h0FEFF, 17'h0FEFF),                     // far corner, full fractions
			load_row(8'd0, 8'd0, 8'd255),
			query_row(17'h00080, 17'h00080),                     // half way between cells
			cfg_row(REG_HEIGHT_SCALE, 16'hFFFF),
			cfg_row(REG_HEIGHT_OFFSET, 16'h7FFF),
			checked_row(17'h0FEFF, 17'h0FEFF, 16'h7FFF, 1'b1),   // clamps high
			cfg_row(REG_HEIGHT_SCALE, 16'h0000),
			cfg_row(REG_HEIGHT_OFFSET, 16'h8000),
			checked_row(17'h00000, 17'h00000, 16'h8000, 1'b1)
		};

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_cfg) begin
				wait_idle();
				write_reg(directed_rows[i].cfg_sel, directed_rows[i].cfg_val);
			end else begin
				send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
			end
		end

		// Random phases, each under its own register setting, the extremes among them.
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			wait_idle();
			case (ph)
				1: begin
					next_scale = 16'h0000;
					next_offset = 16'h8000;
				end
				2: begin
					next_scale = 16'hFFFF;
					next_offset = 16'h7FFF;
				end
				3: begin
					next_scale = 16'hFFFF;
					next_offset = 16'h8000;
				end
				4: begin
					next_scale = 16'h0000;
					next_offset = 16'h7FFF;
				end
				6: begin
					next_scale = SCALE_RESET;
					next_offset = OFFSET_RESET;
				end
				default: begin
					next_scale = 16'($urandom);
					next_offset = 16'($urandom);
				end
			endcase
			write_reg(REG_HEIGHT_SCALE, next_scale);
			write_reg(REG_HEIGHT_OFFSET, next_offset);
			// One phase runs at full rate on both sides; another opens with the long hold-off.
			no_gaps = (ph == 2);
			if (ph == 4) begin
				hold_request = 1'b1;
			end
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end) begin
				pick = $urandom_range(0, 99);
				if (pick < 50 || loaded_patches.size() == 0) begin
					load_patch_and_query();
				end else if (pick < 75) begin
					query_old_patch();
				end else if (pick < 88) begin
					send_item(make_outside_query(), 1'b0, '0);
				end else begin
					send_item(make_load(8'($urandom), 8'($urandom), pick_sample()), 1'b0, '0);
				end
			end
		end

		wait_idle();
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
